@@ hw/rtl/random_spring_scroll_jitter_unit_assert.svh @@
// Assertion macros for the scroll jitter unit checker.
`ifndef RANDOM_SPRING_SCROLL_JITTER_UNIT_ASSERT_SVH
`define RANDOM_SPRING_SCROLL_JITTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RSJ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scroll jitter unit: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RSJ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scroll jitter unit: assertion failed");

`endif

@@ hw/rtl/rsj_pkg.sv @@
// Types, codes and constant tables shared by the scroll jitter unit.
package rsj_pkg;

    localparam int AMP_W       = 4;
    localparam int SPEED_W     = 3;
    localparam int SMOOTH_W    = 3;
    localparam int CFG_DATA_W  = 4;
    localparam int BASE_W      = 5;
    localparam int POS_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int MOD_STEPS   = 8;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

    localparam logic [AMP_W-1:0]    AMP_MAX    = 4'd8;
    localparam logic [SMOOTH_W-1:0] SMOOTH_MIN = 3'd1;
    localparam logic [SMOOTH_W-1:0] SMOOTH_MAX = 3'd4;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    localparam logic [SPEED_W-1:0] SPEED_SLOW   = 3'd1;
    localparam logic [SPEED_W-1:0] SPEED_FAST   = 3'd3;
    localparam logic [SPEED_W-1:0] SPEED_FASTER = 3'd4;
    localparam logic [SPEED_W-1:0] SPEED_EVERY  = 3'd5;

    typedef enum logic [1:0] {
        CFG_AMP_X  = 2'd0,
        CFG_AMP_Y  = 2'd1,
        CFG_SPEED  = 2'd2,
        CFG_SMOOTH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]        func;
        logic [BYTE_W-1:0] rand_pick_x;
        logic [BYTE_W-1:0] rand_gap_x;
        logic [BYTE_W-1:0] rand_pick_y;
        logic [BYTE_W-1:0] rand_gap_y;
    } t_in;

    typedef struct packed {
        logic signed [BYTE_W-1:0] offset_x;
        logic                     offset_x_written;
        logic signed [BYTE_W-1:0] offset_y;
        logic                     offset_y_written;
    } t_out;

    typedef struct packed {
        logic [AMP_W-1:0]    amplitude_x;
        logic [AMP_W-1:0]    amplitude_y;
        logic [SPEED_W-1:0]  speed_code;
        logic [SMOOTH_W-1:0] smoothness;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLR,
        OP_START,
        OP_STOP,
        OP_MOD_INIT,
        OP_MOD_STEP,
        OP_DIRECT,
        OP_TIMER,
        OP_DIFF,
        OP_VEL,
        OP_DAMP,
        OP_POS,
        OP_CLAMP,
        OP_DONE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic axis;
    } t_ctl;

    typedef struct packed {
        logic is_start;
        logic is_stop;
        logic no_tick;
        logic amp_zero;
        logic base_zero;
        logic mod_last;
    } t_stat;

    function automatic logic [AMP_W-1:0] sat_amp(input logic [AMP_W-1:0] a);
        return (a > AMP_MAX) ? AMP_MAX : a;
    endfunction

    function automatic logic [SMOOTH_W-1:0] sat_smooth(input logic [SMOOTH_W-1:0] s);
        logic [SMOOTH_W-1:0] r;
        r = s;
        if (s < SMOOTH_MIN) r = SMOOTH_MIN;
        if (s > SMOOTH_MAX) r = SMOOTH_MAX;
        return r;
    endfunction

    // Base retarget interval in frames; axis 0 is horizontal.
    function automatic logic [BASE_W-1:0] base_interval(input logic [SPEED_W-1:0] speed,
                                                        input logic axis);
        logic [BASE_W-1:0] r;
        unique case (speed)
            SPEED_SLOW:   r = axis ? 5'd25 : 5'd20;
            SPEED_FAST:   r = axis ? 5'd6  : 5'd5;
            SPEED_FASTER: r = axis ? 5'd3  : 5'd2;
            SPEED_EVERY:  r = 5'd0;
            default:      r = axis ? 5'd12 : 5'd10;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/random_spring_scroll_jitter_unit.sv @@
// Top level of the two-axis scroll jitter unit.
//
// The input channel (i_in_valid, o_in_stall, i_in) carries one item per video
// frame: a function code (tick, start or stop) and four random bytes. Each item
// gives exactly one result item on the output channel (o_out_valid,
// i_out_stall, o_out) with the horizontal and vertical offsets and their
// written flags. The configuration channel (i_cfg_valid, o_cfg_ready,
// i_cfg_index, i_cfg_data) is always ready; settings take effect at a start.
// A microcoded sequencer steps one shared datapath through both axes.
// A full spring tick runs the eight-step remainder loop and six easing
// steps per axis. One item is worked on at a time; the next item is
// accepted once the result has moved into the output register, which
// holds it while the receiver stalls.
// A stalled result blocks the next one from leaving the sequencer.
// Reset clears the sequencer and the motion state and restores the default
// configuration.
module random_spring_scroll_jitter_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  rsj_pkg::t_in                       i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output rsj_pkg::t_out                      o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [rsj_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    rsj_pkg::t_cfg  r_cfg;
    rsj_pkg::t_out  r_out;
    logic           r_out_valid;
    rsj_pkg::t_stat stat;
    rsj_pkg::t_ctl  ctl;
    rsj_pkg::t_out  res;
    logic           load;
    logic           push;
    logic           out_free;

    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.amplitude_x <= '0;
            r_cfg.amplitude_y <= '0;
            r_cfg.speed_code  <= 3'd2;
            r_cfg.smoothness  <= 3'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rsj_pkg::CFG_AMP_X:  r_cfg.amplitude_x <= i_cfg_data;
                rsj_pkg::CFG_AMP_Y:  r_cfg.amplitude_y <= i_cfg_data;
                rsj_pkg::CFG_SPEED:  r_cfg.speed_code  <= i_cfg_data[rsj_pkg::SPEED_W-1:0];
                rsj_pkg::CFG_SMOOTH: r_cfg.smoothness  <= i_cfg_data[rsj_pkg::SMOOTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= res;
        end
    end

    rsj_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_load     (load),
        .o_push     (push),
        .o_ctl      (ctl)
    );

    rsj_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_ctl   (ctl),
        .o_stat  (stat),
        .o_res   (res)
    );

endmodule

@@ hw/rtl/rsj_seq.sv @@
// Microcode sequencer: control store, step counter and conditional jumps.
module rsj_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_free,
    input  rsj_pkg::t_stat i_stat,
    output logic          o_in_stall,
    output logic          o_load,
    output logic          o_push,
    output rsj_pkg::t_ctl o_ctl
);

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_START,
        C_STOP,
        C_NOTICK,
        C_AMP0,
        C_MODLOOP,
        C_BASE0,
        C_OUTBUSY
    } t_cond;

    localparam int PC_W = 5;

    localparam logic [PC_W-1:0] S_DISP   = 5'd0;
    localparam logic [PC_W-1:0] S_AXIS_X = 5'd3;
    localparam logic [PC_W-1:0] S_LOOP_X = 5'd4;
    localparam logic [PC_W-1:0] S_AXIS_Y = 5'd12;
    localparam logic [PC_W-1:0] S_LOOP_Y = 5'd13;
    localparam logic [PC_W-1:0] S_DONE   = 5'd21;
    localparam logic [PC_W-1:0] S_START  = 5'd22;
    localparam logic [PC_W-1:0] S_STOP   = 5'd23;

    typedef struct packed {
        rsj_pkg::t_op    op;
        logic            axis;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    function automatic t_uword ucode(input logic [PC_W-1:0] a);
        t_uword w;
        unique case (a)
            5'd0:  w = '{rsj_pkg::OP_CLR,      1'b0, C_START,   S_START};
            5'd1:  w = '{rsj_pkg::OP_NOP,      1'b0, C_STOP,    S_STOP};
            5'd2:  w = '{rsj_pkg::OP_NOP,      1'b0, C_NOTICK,  S_DONE};
            5'd3:  w = '{rsj_pkg::OP_MOD_INIT, 1'b0, C_AMP0,    S_AXIS_Y};
            5'd4:  w = '{rsj_pkg::OP_MOD_STEP, 1'b0, C_MODLOOP, S_LOOP_X};
            5'd5:  w = '{rsj_pkg::OP_DIRECT,   1'b0, C_BASE0,   S_AXIS_Y};
            5'd6:  w = '{rsj_pkg::OP_TIMER,    1'b0, C_NEVER,   S_DISP};
            5'd7:  w = '{rsj_pkg::OP_DIFF,     1'b0, C_NEVER,   S_DISP};
            5'd8:  w = '{rsj_pkg::OP_VEL,      1'b0, C_NEVER,   S_DISP};
            5'd9:  w = '{rsj_pkg::OP_DAMP,     1'b0, C_NEVER,   S_DISP};
            5'd10: w = '{rsj_pkg::OP_POS,      1'b0, C_NEVER,   S_DISP};
            5'd11: w = '{rsj_pkg::OP_CLAMP,    1'b0, C_NEVER,   S_DISP};
            5'd12: w = '{rsj_pkg::OP_MOD_INIT, 1'b1, C_AMP0,    S_DONE};
            5'd13: w = '{rsj_pkg::OP_MOD_STEP, 1'b1, C_MODLOOP, S_LOOP_Y};
            5'd14: w = '{rsj_pkg::OP_DIRECT,   1'b1, C_BASE0,   S_DONE};
            5'd15: w = '{rsj_pkg::OP_TIMER,    1'b1, C_NEVER,   S_DISP};
            5'd16: w = '{rsj_pkg::OP_DIFF,     1'b1, C_NEVER,   S_DISP};
            5'd17: w = '{rsj_pkg::OP_VEL,      1'b1, C_NEVER,   S_DISP};
            5'd18: w = '{rsj_pkg::OP_DAMP,     1'b1, C_NEVER,   S_DISP};
            5'd19: w = '{rsj_pkg::OP_POS,      1'b1, C_NEVER,   S_DISP};
            5'd20: w = '{rsj_pkg::OP_CLAMP,    1'b1, C_NEVER,   S_DISP};
            5'd21: w = '{rsj_pkg::OP_DONE,     1'b0, C_OUTBUSY, S_DONE};
            5'd22: w = '{rsj_pkg::OP_START,    1'b0, C_ALWAYS,  S_DONE};
            5'd23: w = '{rsj_pkg::OP_STOP,     1'b0, C_ALWAYS,  S_DONE};
            default: w = '{rsj_pkg::OP_DONE,   1'b0, C_OUTBUSY, S_DONE};
        endcase
        return w;
    endfunction

    logic            r_busy;
    logic [PC_W-1:0] r_pc;
    t_uword          uw;
    logic            take;
    logic            done_step;

    always_comb begin
        uw = ucode(r_pc);
        unique case (uw.cond)
            C_NEVER:   take = 1'b0;
            C_ALWAYS:  take = 1'b1;
            C_START:   take = i_stat.is_start;
            C_STOP:    take = i_stat.is_stop;
            C_NOTICK:  take = i_stat.no_tick;
            C_AMP0:    take = i_stat.amp_zero;
            C_MODLOOP: take = !i_stat.mod_last;
            C_BASE0:   take = i_stat.base_zero;
            C_OUTBUSY: take = !i_out_free;
            default:   take = 1'b0;
        endcase
    end

    assign done_step  = r_busy && (uw.op == rsj_pkg::OP_DONE);
    assign o_push     = done_step && i_out_free;
    assign o_in_stall = r_busy;
    assign o_load     = i_in_valid && !r_busy;
    assign o_ctl.op   = r_busy ? uw.op : rsj_pkg::OP_NOP;
    assign o_ctl.axis = uw.axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= S_DISP;
        end else if (!r_busy) begin
            if (i_in_valid) begin
                r_busy <= 1'b1;
                r_pc   <= S_DISP;
            end
        end else if (o_push) begin
            r_busy <= 1'b0;
            r_pc   <= S_DISP;
        end else begin
            r_pc <= take ? uw.target : r_pc + 5'd1;
        end
    end

endmodule

@@ hw/rtl/rsj_datapath.sv @@
// Shared datapath: axis state, remainder unit, timer, spring easing and clamp.
module rsj_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  rsj_pkg::t_in   i_in,
    input  rsj_pkg::t_cfg  i_cfg,
    input  rsj_pkg::t_ctl  i_ctl,
    output rsj_pkg::t_stat o_stat,
    output rsj_pkg::t_out  o_res
);

    rsj_pkg::t_in                      r_in;
    rsj_pkg::t_out                     r_res;
    logic                              r_running;
    logic [rsj_pkg::AMP_W-1:0]         r_lamp   [2];
    logic [rsj_pkg::BASE_W-1:0]        r_lbase  [2];
    logic [rsj_pkg::SMOOTH_W-1:0]      r_lsmooth;
    logic [rsj_pkg::POS_W-1:0]         r_tgt    [2];
    logic [rsj_pkg::POS_W-1:0]         r_cur    [2];
    logic [rsj_pkg::POS_W-1:0]         r_vel    [2];
    logic [rsj_pkg::BYTE_W-1:0]        r_timer  [2];
    logic [rsj_pkg::BYTE_W-1:0]        r_gap    [2];
    logic [rsj_pkg::POS_W-1:0]         r_tmp;
    logic [rsj_pkg::AMP_W-1:0]         r_rem;
    logic [rsj_pkg::BYTE_W-1:0]        r_dvd;
    logic [rsj_pkg::MOD_CNT_W-1:0]     r_mcnt;

    logic                              ax;
    logic [rsj_pkg::AMP_W-1:0]         amp_c;
    logic [rsj_pkg::AMP_W-2:0]         half_c;
    logic [rsj_pkg::BASE_W-1:0]        base_c;
    logic [rsj_pkg::BYTE_W-1:0]        pick_c;
    logic [rsj_pkg::BYTE_W-1:0]        gapin_c;
    logic [rsj_pkg::BYTE_W-1:0]        rel_c;
    logic [rsj_pkg::BYTE_W-1:0]        span_c;
    logic [rsj_pkg::AMP_W:0]           mod_t;
    logic [rsj_pkg::AMP_W:0]           dvs_c;
    logic [rsj_pkg::AMP_W:0]           mod_n;
    logic [rsj_pkg::BYTE_W-1:0]        timer_n;
    logic [rsj_pkg::BYTE_W-1:0]        gap_n;
    logic [rsj_pkg::SMOOTH_W-1:0]      sh_c;
    logic [rsj_pkg::POS_W-1:0]         diff_c;
    logic [rsj_pkg::POS_W-1:0]         acc_c;
    logic [rsj_pkg::POS_W-1:0]         prod_c;
    logic [rsj_pkg::POS_W-1:0]         damp_c;
    logic [rsj_pkg::POS_W-1:0]         hi_c;
    logic [rsj_pkg::POS_W-1:0]         lo_c;
    logic [rsj_pkg::POS_W-1:0]         clip_a;
    logic [rsj_pkg::POS_W-1:0]         clip_b;
    logic [rsj_pkg::AMP_W-1:0]         sat_x;
    logic [rsj_pkg::AMP_W-1:0]         sat_y;
    logic [rsj_pkg::BASE_W-1:0]        bx_c;
    logic [rsj_pkg::BASE_W-1:0]        by_c;

    always_comb begin
        ax      = i_ctl.axis;
        amp_c   = r_lamp[ax];
        half_c  = amp_c[rsj_pkg::AMP_W-1:1];
        base_c  = r_lbase[ax];
        pick_c  = ax ? r_in.rand_pick_y : r_in.rand_pick_x;
        gapin_c = ax ? r_in.rand_gap_y  : r_in.rand_gap_x;
        rel_c   = {4'd0, r_rem} - {5'd0, half_c};
        span_c  = {4'd0, amp_c} - {5'd0, half_c};

        mod_t = {r_rem, r_dvd[rsj_pkg::BYTE_W-1]};
        dvs_c = {1'b0, amp_c} + 5'd1;
        mod_n = (mod_t >= dvs_c) ? mod_t - dvs_c : mod_t;

        timer_n = r_timer[ax] + 8'd1;
        gap_n   = {3'd0, base_c} + {5'd0, gapin_c[2:0]};

        sh_c   = r_lsmooth + 3'd1;
        diff_c = r_tgt[ax] - r_cur[ax];
        acc_c  = rsj_pkg::POS_W'($signed(diff_c) >>> sh_c);
        prod_c = {r_vel[ax][rsj_pkg::POS_W-4:0], 3'b000} - r_vel[ax];
        damp_c = rsj_pkg::POS_W'($signed(prod_c) >>> 3);

        hi_c   = {span_c, 8'h00};
        lo_c   = 16'd0 - {5'd0, half_c, 8'h00};
        clip_a = ($signed(r_cur[ax]) > $signed(hi_c)) ? hi_c : r_cur[ax];
        clip_b = ($signed(clip_a) < $signed(lo_c)) ? lo_c : clip_a;

        sat_x = rsj_pkg::sat_amp(i_cfg.amplitude_x);
        sat_y = rsj_pkg::sat_amp(i_cfg.amplitude_y);
        bx_c  = rsj_pkg::base_interval(i_cfg.speed_code, 1'b0);
        by_c  = rsj_pkg::base_interval(i_cfg.speed_code, 1'b1);
    end

    assign o_stat.is_start  = r_in.func == rsj_pkg::FUNC_START;
    assign o_stat.is_stop   = r_in.func == rsj_pkg::FUNC_STOP;
    assign o_stat.no_tick   = (r_in.func != rsj_pkg::FUNC_TICK) || !r_running;
    assign o_stat.amp_zero  = amp_c == '0;
    assign o_stat.base_zero = base_c == '0;
    assign o_stat.mod_last  = r_mcnt == rsj_pkg::MOD_CNT_W'(rsj_pkg::MOD_STEPS - 1);
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_in <= i_in;
        end
        unique case (i_ctl.op)
            rsj_pkg::OP_CLR: begin
                r_res <= '0;
            end
            rsj_pkg::OP_START: begin
                r_res.offset_x_written <= sat_x != '0;
                r_res.offset_y_written <= sat_y != '0;
            end
            rsj_pkg::OP_STOP: begin
                r_res.offset_x_written <= r_lamp[0] != '0;
                r_res.offset_y_written <= r_lamp[1] != '0;
            end
            rsj_pkg::OP_MOD_INIT: begin
                r_rem <= '0;
                r_dvd <= pick_c;
            end
            rsj_pkg::OP_MOD_STEP: begin
                r_rem <= mod_n[rsj_pkg::AMP_W-1:0];
                r_dvd <= {r_dvd[rsj_pkg::BYTE_W-2:0], 1'b0};
            end
            rsj_pkg::OP_DIRECT: begin
                if (base_c == '0) begin
                    if (ax) begin
                        r_res.offset_y         <= rel_c;
                        r_res.offset_y_written <= 1'b1;
                    end else begin
                        r_res.offset_x         <= rel_c;
                        r_res.offset_x_written <= 1'b1;
                    end
                end
            end
            rsj_pkg::OP_DIFF: begin
                r_tmp <= acc_c;
            end
            rsj_pkg::OP_CLAMP: begin
                if (ax) begin
                    r_res.offset_y         <= clip_b[15:8];
                    r_res.offset_y_written <= 1'b1;
                end else begin
                    r_res.offset_x         <= clip_b[15:8];
                    r_res.offset_x_written <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_lsmooth <= '0;
            r_mcnt    <= '0;
            for (int i = 0; i < 2; i++) begin
                r_lamp[i]  <= '0;
                r_lbase[i] <= '0;
                r_tgt[i]   <= '0;
                r_cur[i]   <= '0;
                r_vel[i]   <= '0;
                r_timer[i] <= '0;
                r_gap[i]   <= '0;
            end
        end else begin
            unique case (i_ctl.op)
                rsj_pkg::OP_START: begin
                    r_running  <= 1'b1;
                    r_lamp[0]  <= sat_x;
                    r_lamp[1]  <= sat_y;
                    r_lbase[0] <= bx_c;
                    r_lbase[1] <= by_c;
                    r_lsmooth  <= rsj_pkg::sat_smooth(i_cfg.smoothness);
                    r_gap[0]   <= {3'd0, bx_c};
                    r_gap[1]   <= {3'd0, by_c};
                    for (int i = 0; i < 2; i++) begin
                        r_tgt[i]   <= '0;
                        r_cur[i]   <= '0;
                        r_vel[i]   <= '0;
                        r_timer[i] <= '0;
                    end
                end
                rsj_pkg::OP_STOP: begin
                    r_running <= 1'b0;
                end
                rsj_pkg::OP_MOD_INIT: begin
                    r_mcnt <= '0;
                end
                rsj_pkg::OP_MOD_STEP: begin
                    r_mcnt <= r_mcnt + 1'b1;
                end
                rsj_pkg::OP_TIMER: begin
                    if (timer_n >= r_gap[ax]) begin
                        r_tgt[ax]   <= {rel_c, 8'h00};
                        r_gap[ax]   <= gap_n;
                        r_timer[ax] <= '0;
                    end else begin
                        r_timer[ax] <= timer_n;
                    end
                end
                rsj_pkg::OP_VEL: begin
                    r_vel[ax] <= r_vel[ax] + r_tmp;
                end
                rsj_pkg::OP_DAMP: begin
                    r_vel[ax] <= damp_c;
                end
                rsj_pkg::OP_POS: begin
                    r_cur[ax] <= r_cur[ax] + r_vel[ax];
                end
                rsj_pkg::OP_CLAMP: begin
                    r_cur[ax] <= clip_b;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/rsj_chk.sv @@
// Port-level checker for the scroll jitter unit, bound to the top level.
`include "random_spring_scroll_jitter_unit_assert.svh"

module rsj_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input rsj_pkg::t_out o_out
);

    `RSJ_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `RSJ_ASSERT_NOW(a_result_from_work, $rose(o_out_valid), $past(o_in_stall))
    `RSJ_ASSERT_NOW(a_x_unwritten_zero, o_out_valid && !o_out.offset_x_written, o_out.offset_x == 8'sd0)
    `RSJ_ASSERT_NOW(a_y_unwritten_zero, o_out_valid && !o_out.offset_y_written, o_out.offset_y == 8'sd0)
    `RSJ_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))

endmodule

bind random_spring_scroll_jitter_unit rsj_chk u_rsj_chk (.*);

@@ tb/tb_random_spring_scroll_jitter_unit.sv @@
// Self-checking testbench for the two-axis scroll jitter unit.
`timescale 1ns / 100ps

module tb_random_spring_scroll_jitter_unit;

    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int IN_W = $bits(rsj_pkg::t_in);
    localparam int RANDOM_ITEMS = 1300;

    typedef struct packed {
        logic          is_cfg;
        logic [15:0]   regs;
        rsj_pkg::t_in  item;
        logic          typed;
        rsj_pkg::t_out want;
    } t_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    rsj_pkg::t_in                   i_in = '0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    rsj_pkg::t_out                  o_out;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [1:0]                     i_cfg_index = '0;
    logic [rsj_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [3:0]         cfg_amp_x, cfg_amp_y;
    logic [2:0]         cfg_speed, cfg_smooth;
    logic [3:0]         held_amp [2];
    logic [4:0]         held_base [2];
    logic [2:0]         held_shift;
    logic signed [15:0] goal_pos [2];
    logic signed [15:0] pos [2];
    logic signed [15:0] vel [2];
    logic [7:0]         frame_cnt [2];
    logic [7:0]         retarget_at [2];
    logic               jitter_on;

    rsj_pkg::t_out offsets_due [$];
    rsj_pkg::t_out seen_want;
    int   err_cnt = 0;
    int   items_sent = 0;
    int   burst_left = 0;
    int   seg_left = 0;
    int   run_left = 0;
    logic [1:0] stall_mode = 2'd0;

    random_spring_scroll_jitter_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [7:0] axis_step(input int ax, input logic [7:0] pick,
                                             input logic [7:0] gap);
        int amp, half, r;
        logic signed [15:0] centered, diff, accel, prod, lo, hi;
        amp = held_amp[ax];
        half = amp / 2;
        r = pick % (amp + 1);
        centered = 16'(r - half);
        if (held_base[ax] == 5'd0) begin
            return centered[7:0];
        end
        frame_cnt[ax] = frame_cnt[ax] + 8'd1;
        if (frame_cnt[ax] >= retarget_at[ax]) begin
            goal_pos[ax] = centered << 8;
            retarget_at[ax] = 8'(held_base[ax]) + 8'(gap[2:0]);
            frame_cnt[ax] = 8'd0;
        end
        diff = goal_pos[ax] - pos[ax];
        accel = diff >>> (held_shift + 1);
        vel[ax] = vel[ax] + accel;
        prod = vel[ax] * 16'sd7;
        vel[ax] = prod >>> 3;
        pos[ax] = pos[ax] + vel[ax];
        lo = 16'(-half * 256);
        hi = 16'((amp - half) * 256);
        if (pos[ax] > hi) pos[ax] = hi;
        if (pos[ax] < lo) pos[ax] = lo;
        return pos[ax][15:8];
    endfunction

    function automatic rsj_pkg::t_out jitter_step(input rsj_pkg::t_in it);
        rsj_pkg::t_out res;
        res = '0;
        case (it.func)
            rsj_pkg::FUNC_START: begin
                held_amp[0] = (cfg_amp_x > rsj_pkg::AMP_MAX) ? rsj_pkg::AMP_MAX : cfg_amp_x;
                held_amp[1] = (cfg_amp_y > rsj_pkg::AMP_MAX) ? rsj_pkg::AMP_MAX : cfg_amp_y;
                held_shift = (cfg_smooth < rsj_pkg::SMOOTH_MIN) ? rsj_pkg::SMOOTH_MIN :
                             (cfg_smooth > rsj_pkg::SMOOTH_MAX) ? rsj_pkg::SMOOTH_MAX :
                             cfg_smooth;
                case (cfg_speed)
                    rsj_pkg::SPEED_SLOW: begin
                        held_base[0] = 5'd20;
                        held_base[1] = 5'd25;
                    end
                    rsj_pkg::SPEED_FAST: begin
                        held_base[0] = 5'd5;
                        held_base[1] = 5'd6;
                    end
                    rsj_pkg::SPEED_FASTER: begin
                        held_base[0] = 5'd2;
                        held_base[1] = 5'd3;
                    end
                    rsj_pkg::SPEED_EVERY: begin
                        held_base[0] = 5'd0;
                        held_base[1] = 5'd0;
                    end
                    default: begin
                        held_base[0] = 5'd10;
                        held_base[1] = 5'd12;
                    end
                endcase
                for (int ax = 0; ax < 2; ax++) begin
                    goal_pos[ax] = '0;
                    pos[ax] = '0;
                    vel[ax] = '0;
                    frame_cnt[ax] = '0;
                    retarget_at[ax] = 8'(held_base[ax]);
                end
                jitter_on = 1'b1;
                res.offset_x_written = (held_amp[0] != 0);
                res.offset_y_written = (held_amp[1] != 0);
            end
            rsj_pkg::FUNC_STOP: begin
                jitter_on = 1'b0;
                res.offset_x_written = (held_amp[0] != 0);
                res.offset_y_written = (held_amp[1] != 0);
            end
            rsj_pkg::FUNC_TICK: begin
                if (jitter_on && held_amp[0] != 0) begin
                    res.offset_x = axis_step(0, it.rand_pick_x, it.rand_gap_x);
                    res.offset_x_written = 1'b1;
                end
                if (jitter_on && held_amp[1] != 0) begin
                    res.offset_y = axis_step(1, it.rand_pick_y, it.rand_gap_y);
                    res.offset_y_written = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_row row_cfg(input logic [3:0] ax, ay, sp, sm);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.regs = {sm, sp, ay, ax};
        return r;
    endfunction

    function automatic t_row row_in(input logic [1:0] f, input logic [7:0] px, gx, py, gy);
        t_row r;
        r = '0;
        r.item = '{func: f, rand_pick_x: px, rand_gap_x: gx, rand_pick_y: py,
                   rand_gap_y: gy};
        return r;
    endfunction

    function automatic t_row row_chk(input logic [1:0] f, input logic [7:0] px, gx, py, gy,
                                     input rsj_pkg::t_out want);
        t_row r;
        r = row_in(f, px, gx, py, gy);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic rsj_pkg::t_in rand_item(input logic [1:0] f);
        rsj_pkg::t_in it;
        it = IN_W'({$urandom, $urandom});
        it.func = f;
        return it;
    endfunction

    task automatic put_item(input rsj_pkg::t_in it, input logic typed,
                            input rsj_pkg::t_out want);
        int gap;
        rsj_pkg::t_out res;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            i_in <= IN_W'({$urandom, $urandom});
            repeat (gap) @(posedge i_clk);
        end
        i_in <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        res = jitter_step(it);
        offsets_due.push_back(typed ? want : res);
        items_sent++;
    endtask

    // Registers change only once every result has left the block.
    task automatic set_config(input logic [15:0] regs);
        i_in_valid <= 1'b0;
        while (offsets_due.size() != 0) @(posedge i_clk);
        for (int k = 0; k < 4; k++) begin
            i_cfg_index <= rsj_pkg::t_cfg_idx'(k);
            i_cfg_data <= regs[4*k +: 4];
            i_cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!o_cfg_ready);
            case (rsj_pkg::t_cfg_idx'(k))
                rsj_pkg::CFG_AMP_X:  cfg_amp_x = regs[3:0];
                rsj_pkg::CFG_AMP_Y:  cfg_amp_y = regs[7:4];
                rsj_pkg::CFG_SPEED:  cfg_speed = regs[10:8];
                rsj_pkg::CFG_SMOOTH: cfg_smooth = regs[14:12];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (seg_left == 0) begin
            seg_left <= $urandom_range(50, 300);
            stall_mode <= 2'($urandom_range(0, 2));
            i_out_stall <= 1'b0;
        end else begin
            seg_left <= seg_left - 1;
            case (stall_mode)
                2'd0: i_out_stall <= 1'b0;
                2'd1: i_out_stall <= ($urandom_range(0, 2) == 0);
                default: begin
                    if (run_left == 0) begin
                        i_out_stall <= !i_out_stall;
                        run_left <= !i_out_stall ? $urandom_range(1, 20) : $urandom_range(1, 10);
                    end else begin
                        run_left <= run_left - 1;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (offsets_due.size() == 0) begin
                $error("result item arrived with no expected item pending");
                err_cnt++;
            end else begin
                seen_want = offsets_due.pop_front();
                if (o_out.offset_x !== seen_want.offset_x) begin
                    $error("offset_x: expected %0d, got %0d", seen_want.offset_x, o_out.offset_x);
                    err_cnt++;
                end
                if (o_out.offset_x_written !== seen_want.offset_x_written) begin
                    $error("offset_x_written: expected %0b, got %0b",
                           seen_want.offset_x_written, o_out.offset_x_written);
                    err_cnt++;
                end
                if (o_out.offset_y !== seen_want.offset_y) begin
                    $error("offset_y: expected %0d, got %0d", seen_want.offset_y, o_out.offset_y);
                    err_cnt++;
                end
                if (o_out.offset_y_written !== seen_want.offset_y_written) begin
                    $error("offset_y_written: expected %0b, got %0b",
                           seen_want.offset_y_written, o_out.offset_y_written);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        t_row plan [$];
        rsj_pkg::t_out none, both;
        logic [3:0] ax_v, ay_v, sp_v, sm_v;
        int n, sel, ph;
        logic [1:0] f;

        cfg_amp_x = 4'd0;
        cfg_amp_y = 4'd0;
        cfg_speed = 3'd2;
        cfg_smooth = 3'd1;
        held_shift = '0;
        jitter_on = 1'b0;
        for (int ax = 0; ax < 2; ax++) begin
            held_amp[ax] = '0;
            held_base[ax] = '0;
            goal_pos[ax] = '0;
            pos[ax] = '0;
            vel[ax] = '0;
            frame_cnt[ax] = '0;
            retarget_at[ax] = '0;
        end

        none = '0;
        both = {8'h00, 1'b1, 8'h00, 1'b1};
        plan = {
            row_chk(rsj_pkg::FUNC_TICK,  8'h00, 8'h00, 8'h00, 8'h00, none),
            row_chk(rsj_pkg::FUNC_STOP,  8'hFF, 8'hFF, 8'hFF, 8'hFF, none),
            row_chk(FUNC_SPARE,          8'h55, 8'hAA, 8'h55, 8'hAA, none),
            row_chk(rsj_pkg::FUNC_START, 8'hAA, 8'h55, 8'hAA, 8'h55, none),
            row_chk(rsj_pkg::FUNC_TICK,  8'hFF, 8'hFF, 8'hFF, 8'hFF, none),
            row_cfg(4'd15, 4'd8, 4'(rsj_pkg::SPEED_EVERY), 4'd0),
            row_chk(rsj_pkg::FUNC_START, 8'h00, 8'h00, 8'h00, 8'h00, both),
            row_chk(rsj_pkg::FUNC_TICK,  8'h00, 8'h00, 8'h00, 8'h00,
                    {8'hFC, 1'b1, 8'hFC, 1'b1}),
            row_chk(rsj_pkg::FUNC_TICK,  8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    {8'hFF, 1'b1, 8'hFF, 1'b1}),
            row_in(rsj_pkg::FUNC_TICK,   8'h08, 8'h00, 8'h04, 8'h00),
            row_chk(rsj_pkg::FUNC_STOP,  8'h12, 8'h34, 8'h56, 8'h78, both),
            row_chk(rsj_pkg::FUNC_TICK,  8'h12, 8'h34, 8'h56, 8'h78, none),
            row_cfg(4'd1, 4'd0, 4'(rsj_pkg::SPEED_FASTER), 4'd7),
            row_chk(rsj_pkg::FUNC_START, 8'h00, 8'h00, 8'h00, 8'h00,
                    {8'h00, 1'b1, 8'h00, 1'b0}),
            row_in(rsj_pkg::FUNC_TICK,   8'hFF, 8'h00, 8'hFF, 8'h00),
            row_in(rsj_pkg::FUNC_TICK,   8'h01, 8'hFF, 8'h01, 8'hFF),
            row_in(rsj_pkg::FUNC_TICK,   8'h00, 8'h07, 8'h00, 8'h07),
            row_in(rsj_pkg::FUNC_TICK,   8'hFF, 8'hF8, 8'hFF, 8'hF8),
            row_cfg(4'd2, 4'd9, 4'(rsj_pkg::SPEED_SLOW), 4'd4),
            row_chk(rsj_pkg::FUNC_START, 8'h00, 8'h00, 8'h00, 8'h00, both),
            row_in(rsj_pkg::FUNC_TICK,   8'hFF, 8'h07, 8'hFF, 8'h07),
            row_in(rsj_pkg::FUNC_TICK,   8'h00, 8'h00, 8'h07, 8'h00),
            row_in(rsj_pkg::FUNC_TICK,   8'h80, 8'h03, 8'h80, 8'h03),
            row_in(rsj_pkg::FUNC_TICK,   8'h7F, 8'hFC, 8'h7F, 8'hFC),
            row_cfg(4'd0, 4'd0, 4'(rsj_pkg::SPEED_FAST), 4'd2),
            row_in(rsj_pkg::FUNC_TICK,   8'h02, 8'h01, 8'h08, 8'h01),
            row_chk(FUNC_SPARE,          8'hFF, 8'hFF, 8'hFF, 8'hFF, none),
            row_chk(rsj_pkg::FUNC_STOP,  8'h00, 8'h00, 8'h00, 8'h00, both)
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) set_config(plan[i].regs);
            else put_item(plan[i].item, plan[i].typed, plan[i].want);
        end

        // Each phase is a start followed by a run of mostly ticks.
        ph = 0;
        while (items_sent < plan.size() + RANDOM_ITEMS) begin
            if (ph == 0) begin
                ax_v = 4'd15;
                ay_v = 4'd15;
                sm_v = 4'd15;
            end else if (ph == 1) begin
                ax_v = 4'd1;
                ay_v = 4'd1;
                sm_v = 4'd1;
            end else begin
                ax_v = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(1, 8));
                ay_v = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(1, 8));
                sm_v = 4'($urandom_range(0, 15));
            end
            sp_v = (ph < 8) ? 4'(ph) : 4'($urandom_range(0, 15));
            set_config({sm_v, sp_v, ay_v, ax_v});
            put_item(rand_item(rsj_pkg::FUNC_START), 1'b0, none);
            n = $urandom_range(40, 140);
            repeat (n) begin
                sel = $urandom_range(0, 99);
                f = (sel < 88) ? rsj_pkg::FUNC_TICK : (sel < 92) ? rsj_pkg::FUNC_START :
                    (sel < 96) ? rsj_pkg::FUNC_STOP : FUNC_SPARE;
                put_item(rand_item(f), 1'b0, none);
            end
            if ($urandom_range(0, 1) == 0) put_item(rand_item(rsj_pkg::FUNC_STOP), 1'b0, none);
            ph++;
        end

        i_in_valid <= 1'b0;
        while (offsets_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
